FILE: sv/bdgm_pkg.sv
package bdgm_pkg;

  localparam int unsigned BUTTON_COUNT = 16;
  localparam int unsigned BTN_W        = $clog2(BUTTON_COUNT);
  localparam int unsigned LIMIT_W      = 4;
  localparam int unsigned TARGET_W     = 5;
  localparam int unsigned ANGLE_W      = 10;
  localparam int unsigned HAT_COUNT    = 2;
  localparam int unsigned DIR_COUNT    = 4;

  localparam logic [LIMIT_W-1:0]  LIMIT_RESET     = LIMIT_W'(10);
  localparam logic [BTN_W-1:0]    SHIFT_BTN_RESET = BTN_W'(12);
  localparam logic [TARGET_W-1:0] SHIFT_OFFSET    = TARGET_W'(5);

  localparam logic signed [ANGLE_W-1:0] HAT_CENTER = ANGLE_W'(-1);

  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_HAT     = 2'd2
  } report_kind_e;

  typedef enum logic {
    CFG_DEBOUNCE_LIMIT = 1'b0,
    CFG_SHIFT_BUTTON   = 1'b1
  } cfg_index_e;

  // Direction code doubles as the bit position in a hat's held vector.
  typedef enum logic [1:0] {
    DIR_0   = 2'd0,
    DIR_90  = 2'd1,
    DIR_180 = 2'd2,
    DIR_270 = 2'd3
  } hat_dir_e;

  typedef struct packed {
    logic                is_hat;
    logic [TARGET_W-1:0] id;
    hat_dir_e            dir;
  } map_entry_t;

  function automatic map_entry_t normal_map(input logic [BTN_W-1:0] btn);
    map_entry_t e;
    unique case (btn)
      4'd0:  e = '{1'b0, TARGET_W'(0), DIR_0};
      4'd1:  e = '{1'b0, TARGET_W'(5), DIR_0};
      4'd2:  e = '{1'b0, TARGET_W'(4), DIR_0};
      4'd3:  e = '{1'b0, TARGET_W'(1), DIR_0};
      4'd4:  e = '{1'b1, TARGET_W'(1), DIR_270};
      4'd5:  e = '{1'b1, TARGET_W'(1), DIR_180};
      4'd6:  e = '{1'b1, TARGET_W'(1), DIR_90};
      4'd7:  e = '{1'b1, TARGET_W'(1), DIR_0};
      4'd8:  e = '{1'b1, TARGET_W'(0), DIR_0};
      4'd9:  e = '{1'b1, TARGET_W'(0), DIR_90};
      4'd10: e = '{1'b1, TARGET_W'(0), DIR_180};
      4'd11: e = '{1'b1, TARGET_W'(0), DIR_270};
      4'd12: e = '{1'b0, TARGET_W'(0), DIR_0};
      4'd13: e = '{1'b0, TARGET_W'(2), DIR_0};
      4'd14: e = '{1'b0, TARGET_W'(3), DIR_0};
      default: e = '{1'b0, TARGET_W'(0), DIR_0};
    endcase
    return e;
  endfunction

  function automatic logic [TARGET_W-1:0] shift_map(input logic [BTN_W-1:0] btn);
    logic [TARGET_W-1:0] t;
    unique case (btn)
      4'd0:  t = TARGET_W'(0);
      4'd1:  t = TARGET_W'(5);
      4'd2:  t = TARGET_W'(4);
      4'd3:  t = TARGET_W'(1);
      4'd4:  t = TARGET_W'(6);
      4'd5:  t = TARGET_W'(7);
      4'd6:  t = TARGET_W'(8);
      4'd7:  t = TARGET_W'(9);
      4'd8:  t = TARGET_W'(10);
      4'd9:  t = TARGET_W'(11);
      4'd10: t = TARGET_W'(12);
      4'd11: t = TARGET_W'(13);
      4'd13: t = TARGET_W'(2);
      4'd14: t = TARGET_W'(3);
      4'd15: t = TARGET_W'(0);
      default: t = TARGET_W'(0);
    endcase
    // Button 12, the reset shift button, maps to button 0 with no offset.
    return (btn == BTN_W'(12)) ? t : t + SHIFT_OFFSET;
  endfunction

  // Held vector bit order: {270, 180, 90, 0}.
  function automatic logic signed [ANGLE_W-1:0] hat_angle(input logic [DIR_COUNT-1:0] held);
    logic signed [ANGLE_W-1:0] a;
    unique case (held)
      4'b0001: a = ANGLE_W'(0);
      4'b0010: a = ANGLE_W'(90);
      4'b0100: a = ANGLE_W'(180);
      4'b1000: a = ANGLE_W'(270);
      4'b0011: a = ANGLE_W'(45);
      4'b0101: a = ANGLE_W'(90);
      4'b1001: a = ANGLE_W'(315);
      4'b0110: a = ANGLE_W'(135);
      4'b1010: a = ANGLE_W'(180);
      4'b1100: a = ANGLE_W'(225);
      default: a = HAT_CENTER;
    endcase
    return a;
  endfunction

endpackage

FILE: sv/button_debounce_gamepad_mapper.sv
// Debounces raw contact samples of a 16-button matrix and maps the settled
// edges onto gamepad reports. Each input word is one sample for one button:
// that button's counter steps up on a closed contact and down on an open
// one, clamped to 0..debounce_limit (a limit of 0 acts as 1). Reaching the
// limit is a press, reaching 0 is a release; any other sample yields no
// output word. The shift button sets the shift layer, which remaps every
// button to a plain gamepad button. In the normal layer, eight buttons form
// two 4-way hats and produce a hat update with the recomputed angle (-1
// centered, one direction, mean of two, 315 for up-left, -1 for three or
// more). Throughput is one word per cycle while the output is not stalled:
// a sample passes through the input register, where its counter update,
// table lookup and hat compare complete, and lands in the output register.
// Output valid is registered from the input register; a stalled output
// holds the input. Write the two config registers only while the block
// is idle.
module button_debounce_gamepad_mapper
  import bdgm_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Config write port
  input  logic                      cfg_we_i,
  input  logic                      cfg_index_i,
  input  logic [LIMIT_W-1:0]        cfg_data_i,
  // Sample input
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [BTN_W-1:0]          button_index_i,
  input  logic                      contact_closed_i,
  // Report output
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                report_kind_o,
  output logic [TARGET_W-1:0]       report_target_o,
  output logic signed [ANGLE_W-1:0] hat_angle_o
);

  // Config registers
  logic [LIMIT_W-1:0] limit_q;
  logic [BTN_W-1:0]   shift_btn_q;

  // Debounce state
  logic [LIMIT_W-1:0] counts_q [BUTTON_COUNT];
  logic               shift_q;

  // Input register
  logic               in_valid_q;
  logic [BTN_W-1:0]   in_btn_q;
  logic               in_closed_q;

  // Output register
  logic                      out_valid_q;
  logic [1:0]                kind_q;
  logic [TARGET_W-1:0]       target_q;
  logic signed [ANGLE_W-1:0] angle_q;

  // Move the held word forward whenever the output slot is free or draining.
  logic advance;
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Counter step for the held sample.
  logic [LIMIT_W-1:0] eff_limit;
  logic [LIMIT_W-1:0] old_cnt;
  logic [LIMIT_W:0]   raw_cnt;
  logic [LIMIT_W-1:0] new_cnt;
  logic               changed;
  logic               emit;
  logic               pressed;
  logic               shift_d;

  always_comb begin
    eff_limit = (limit_q == '0) ? LIMIT_W'(1) : limit_q;
    old_cnt   = counts_q[in_btn_q];
    if (in_closed_q) begin
      raw_cnt = {1'b0, old_cnt} + (LIMIT_W+1)'(1);
    end else begin
      raw_cnt = (old_cnt == '0) ? '0 : {1'b0, old_cnt} - (LIMIT_W+1)'(1);
    end
    // Clamp also pulls a counter down after the limit was lowered.
    new_cnt = (raw_cnt > {1'b0, eff_limit}) ? eff_limit : raw_cnt[LIMIT_W-1:0];
    changed = (new_cnt != old_cnt);
    pressed = (new_cnt == eff_limit);
    emit    = changed && (pressed || (new_cnt == '0));
    shift_d = (emit && (in_btn_q == shift_btn_q)) ? pressed : shift_q;
  end

  // Held vectors of both hats, seen with this sample's update applied.
  logic [DIR_COUNT-1:0] held [HAT_COUNT];
  map_entry_t           scan_e;
  logic [LIMIT_W-1:0]   scan_cnt;

  always_comb begin
    scan_e   = '0;
    scan_cnt = '0;
    for (int h = 0; h < HAT_COUNT; h++) begin
      held[h] = '0;
    end
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      scan_e   = normal_map(BTN_W'(i));
      scan_cnt = (BTN_W'(i) == in_btn_q) ? new_cnt : counts_q[i];
      for (int h = 0; h < HAT_COUNT; h++) begin
        if (scan_e.is_hat && (scan_e.id == TARGET_W'(h)) && (scan_cnt == eff_limit)) begin
          held[h][scan_e.dir] = 1'b1;
        end
      end
    end
  end

  // Map the event through the active layer.
  map_entry_t                norm_e;
  logic [1:0]                kind_d;
  logic [TARGET_W-1:0]       target_d;
  logic signed [ANGLE_W-1:0] angle_d;

  always_comb begin
    norm_e = normal_map(in_btn_q);
    if (shift_d) begin
      kind_d   = pressed ? KIND_PRESS : KIND_RELEASE;
      target_d = shift_map(in_btn_q);
      angle_d  = '0;
    end else if (norm_e.is_hat) begin
      kind_d   = KIND_HAT;
      target_d = norm_e.id;
      angle_d  = hat_angle(held[norm_e.id[0]]);
    end else begin
      kind_d   = pressed ? KIND_PRESS : KIND_RELEASE;
      target_d = norm_e.id;
      angle_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LIMIT_RESET;
      shift_btn_q <= SHIFT_BTN_RESET;
      shift_q     <= 1'b0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        counts_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_DEBOUNCE_LIMIT: limit_q     <= cfg_data_i;
          CFG_SHIFT_BUTTON:   shift_btn_q <= BTN_W'(cfg_data_i);
          default: ;
        endcase
      end

      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end

      if (advance) begin
        // Commit state and drop words that settle nothing.
        if (changed) begin
          counts_q[in_btn_q] <= new_cnt;
        end
        shift_q     <= shift_d;
        out_valid_q <= emit;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_btn_q    <= button_index_i;
      in_closed_q <= contact_closed_i;
    end
    if (advance && emit) begin
      kind_q   <= kind_d;
      target_q <= target_d;
      angle_q  <= angle_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign report_kind_o   = kind_q;
  assign report_target_o = target_q;
  assign hat_angle_o     = angle_q;

  // Button reports carry a zero angle.
  a_button_angle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (report_kind_o != KIND_HAT) |-> hat_angle_o == '0)
    else $error("button report with nonzero angle");

  // Hat updates name one of the two hats.
  a_hat_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (report_kind_o == KIND_HAT) |-> report_target_o < TARGET_W'(HAT_COUNT))
    else $error("hat update with bad hat number");

  // Input stalls only behind a blocked output word.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled without output backpressure");

  // A counter never leaves the configured range once a sample settled it.
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && changed |=> counts_q[$past(in_btn_q)] <= $past(eff_limit))
    else $error("counter above limit");

endmodule

FILE: tb/button_debounce_gamepad_mapper_test.sv
module button_debounce_gamepad_mapper_test;
  import bdgm_pkg::*;

  // Cycles without any accepted word before the run is declared hung.
  localparam int STALL_LIMIT = 2000;
  // Settle time after the last report: covers a sample still in the pipe.
  localparam int PIPE_FLUSH = 4;
  // Two held directions that straddle the wrap report the diagonal.
  localparam int WRAP_DIAGONAL = 315;
  localparam int DEG_0 = 0;
  localparam int DEG_270 = 270;

  // Normal layer: gamepad button or hat number per matrix button.
  localparam logic [TARGET_W-1:0] PAD_TARGET [BUTTON_COUNT] =
    '{0, 5, 4, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 2, 3, 0};
  localparam logic [BUTTON_COUNT-1:0] HAT_BUTTONS = 16'h0FF0;
  localparam int HAT_DEGREES [BUTTON_COUNT] =
    '{0, 0, 0, 0, 270, 180, 90, 0, 0, 90, 180, 270, 0, 0, 0, 0};
  // Shift layer: every button is a plain gamepad button.
  localparam logic [TARGET_W-1:0] SHIFT_TARGET [BUTTON_COUNT] =
    '{5, 10, 9, 6, 11, 12, 13, 14, 15, 16, 17, 18, 0, 7, 8, 5};

  // Per-block register settings of the random part; extremes included.
  localparam logic [LIMIT_W-1:0] BLOCK_LIMIT [9] = '{15, 1, 4, 2, 15, 3, 0, 7, 1};
  localparam logic [BTN_W-1:0]   BLOCK_SHIFT [9] = '{0, 15, 12, 8, 3, 12, 5, 11, 0};

  typedef struct {
    logic [BTN_W-1:0] btn;
    logic             closed;
  } contact_sample_t;

  typedef struct {
    report_kind_e              kind;
    logic [TARGET_W-1:0]       target;
    logic signed [ANGLE_W-1:0] angle;
  } gamepad_report_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic                      cfg_index_i = 1'b0;
  logic [LIMIT_W-1:0]        cfg_data_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic [BTN_W-1:0]          button_index_i = '0;
  logic                      contact_closed_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [1:0]                report_kind_o;
  logic [TARGET_W-1:0]       report_target_o;
  logic signed [ANGLE_W-1:0] hat_angle_o;

  button_debounce_gamepad_mapper dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .button_index_i   (button_index_i),
    .contact_closed_i (contact_closed_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .report_kind_o    (report_kind_o),
    .report_target_o  (report_target_o),
    .hat_angle_o      (hat_angle_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Mirror of the block state, updated as each sample word is accepted.
  logic [LIMIT_W-1:0] debounce_count [BUTTON_COUNT];
  logic               shift_layer;
  logic [LIMIT_W-1:0] limit_reg;
  logic [BTN_W-1:0]   shift_btn_reg;

  contact_sample_t sample_fifo [$];
  gamepad_report_t report_fifo [$];

  int send_idle_pct = 33;
  int recv_idle_pct = 64;
  int mismatches = 0;
  int stall_cycles = 0;
  gamepad_report_t got_want;

  initial begin
    for (int b = 0; b < BUTTON_COUNT; b++) debounce_count[b] = '0;
    shift_layer   = 1'b0;
    limit_reg     = LIMIT_RESET;
    shift_btn_reg = SHIFT_BTN_RESET;
  end

  function automatic int active_limit();
    return (limit_reg == 0) ? 1 : int'(limit_reg);
  endfunction

  // Angle of one hat from the directions currently held at the limit.
  // Directions are collected in button order.
  function automatic int hat_position(input logic [TARGET_W-1:0] hat);
    int held_n;
    int first_deg;
    int second_deg;
    held_n = 0;
    first_deg = 0;
    second_deg = 0;
    for (int b = 0; b < BUTTON_COUNT; b++) begin
      if (HAT_BUTTONS[b] && PAD_TARGET[b] == hat &&
          int'(debounce_count[b]) == active_limit()) begin
        if (held_n == 0) first_deg = HAT_DEGREES[b];
        else if (held_n == 1) second_deg = HAT_DEGREES[b];
        held_n++;
      end
    end
    if (held_n == 1) return first_deg;
    if (held_n == 2) begin
      if ((first_deg == DEG_0 && second_deg == DEG_270) ||
          (first_deg == DEG_270 && second_deg == DEG_0))
        return WRAP_DIAGONAL;
      return (first_deg + second_deg) / 2;
    end
    return int'(HAT_CENTER);
  endfunction

  // Step one button's integrator and queue the report the step produces.
  task automatic settle_sample(input logic [BTN_W-1:0] btn, input logic closed);
    int lim;
    int prev;
    int next;
    logic pressed;
    gamepad_report_t rep;
    lim  = active_limit();
    prev = int'(debounce_count[btn]);
    if (closed) next = prev + 1;
    else next = (prev == 0) ? 0 : prev - 1;
    // Clamp also pulls a counter down after the limit was lowered.
    if (next > lim) next = lim;
    if (next == prev) return;
    debounce_count[btn] = LIMIT_W'(next);
    if (next != 0 && next != lim) return;
    pressed = (next == lim);
    // The shift button changes layers before its own lookup.
    if (btn == shift_btn_reg) shift_layer = pressed;
    rep.kind   = pressed ? KIND_PRESS : KIND_RELEASE;
    rep.target = PAD_TARGET[btn];
    rep.angle  = '0;
    if (shift_layer) begin
      rep.target = SHIFT_TARGET[btn];
    end else if (HAT_BUTTONS[btn]) begin
      rep.kind  = KIND_HAT;
      rep.angle = ANGLE_W'(hat_position(PAD_TARGET[btn]));
    end
    report_fifo.push_back(rep);
  endtask

  task automatic note_mismatch(input string what, input int got, input int want);
    if (mismatches < 40)
      $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // Sample driver: hold the word until taken, then advance or idle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) settle_sample(button_index_i, contact_closed_i);
      if (!in_valid_i || in_ready_o) begin
        if (sample_fifo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i       <= 1'b1;
          button_index_i   <= sample_fifo[0].btn;
          contact_closed_i <= sample_fifo[0].closed;
          void'(sample_fifo.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Report monitor, receiver stalls and the hang watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (report_fifo.size() == 0) begin
          note_mismatch("unexpected report, kind", int'(report_kind_o), -1);
        end else begin
          got_want = report_fifo.pop_front();
          if (report_kind_o !== got_want.kind)
            note_mismatch("report_kind", int'(report_kind_o), int'(got_want.kind));
          if (report_target_o !== got_want.target)
            note_mismatch("report_target", int'(report_target_o), int'(got_want.target));
          if (hat_angle_o !== got_want.angle)
            note_mismatch("hat_angle", int'(hat_angle_o), int'(got_want.angle));
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL button_debounce_gamepad_mapper");
      $finish;
    end
  end

  task automatic queue_sample(input logic [BTN_W-1:0] btn, input logic closed);
    contact_sample_t s;
    s.btn    = btn;
    s.closed = closed;
    sample_fifo.push_back(s);
  endtask

  // Drain: wait until every sample is taken and every report is back,
  // then let a sample that yields no report leave the pipe.
  task automatic wait_idle();
    while (sample_fifo.size() != 0 || in_valid_i || report_fifo.size() != 0)
      @(posedge clk_i);
    repeat (PIPE_FLUSH) @(posedge clk_i);
  endtask

  task automatic set_register(input cfg_index_e idx, input logic [LIMIT_W-1:0] value);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_DEBOUNCE_LIMIT) limit_reg = value;
    else shift_btn_reg = value;
  endtask

  // Mostly runs of one contact level on one button, up to two samples longer
  // than the limit, with flipped samples as bounce; the rest is pure noise.
  task automatic queue_bursts(input int count);
    int made;
    int run;
    logic [BTN_W-1:0] btn;
    logic level;
    made = 0;
    while (made < count) begin
      if ($urandom_range(99) < 20) begin
        queue_sample(BTN_W'($urandom_range(BUTTON_COUNT - 1)), 1'($urandom_range(1)));
        made++;
      end else begin
        btn = ($urandom_range(99) < 15) ? shift_btn_reg
                                        : BTN_W'($urandom_range(BUTTON_COUNT - 1));
        level = 1'($urandom_range(1));
        run = $urandom_range(active_limit() + 2, 1);
        repeat (run) begin
          queue_sample(btn, level ^ ($urandom_range(99) < 8));
          made++;
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Limit 1: a closed sample presses, an open one releases, unless the counter is already there.
    set_register(CFG_DEBOUNCE_LIMIT, 1);
    queue_sample(0, 1'b1);
    queue_sample(0, 1'b1);   // counter already at limit: no report
    queue_sample(0, 1'b0);
    queue_sample(0, 1'b0);   // counter already at zero: no report
    queue_sample(8, 1'b1);   // hat 0, one direction
    queue_sample(11, 1'b1);  // wrap pair gives the diagonal
    queue_sample(9, 1'b1);   // three held: centered
    queue_sample(8, 1'b0);
    queue_sample(11, 1'b0);
    queue_sample(9, 1'b0);
    queue_sample(12, 1'b1);  // shift on before its own lookup
    queue_sample(4, 1'b1);   // hat button in shift layer is a plain button
    queue_sample(15, 1'b1);
    queue_sample(12, 1'b0);  // shift off before its own lookup
    queue_sample(4, 1'b0);   // release in normal layer: hat update
    queue_sample(15, 1'b0);

    // Zero limit acts as one.
    set_register(CFG_DEBOUNCE_LIMIT, 0);
    queue_sample(1, 1'b1);
    queue_sample(1, 1'b0);

    // Lower the limit under a settled counter: next sample clamps and presses.
    set_register(CFG_DEBOUNCE_LIMIT, 3);
    repeat (3) queue_sample(5, 1'b1);
    set_register(CFG_DEBOUNCE_LIMIT, 2);
    queue_sample(5, 1'b1);
    queue_sample(5, 1'b0);
    queue_sample(5, 1'b0);

    for (int blk = 0; blk < 9; blk++) begin
      set_register(CFG_DEBOUNCE_LIMIT, BLOCK_LIMIT[blk]);
      set_register(CFG_SHIFT_BUTTON, BLOCK_SHIFT[blk]);
      // Swap idle rates, then run with neither side idling.
      if (blk < 3) begin
        send_idle_pct = 33;
        recv_idle_pct = 64;
      end else if (blk < 6) begin
        send_idle_pct = 64;
        recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      queue_bursts(70);
      // Hold the sender until every report of the first half is back.
      wait_idle();
      queue_bursts(72);
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("PASS button_debounce_gamepad_mapper");
    end else begin
      $display("FAIL button_debounce_gamepad_mapper");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/bdgm_pkg.sv
sv/button_debounce_gamepad_mapper.sv
tb/button_debounce_gamepad_mapper_test.sv
